// ===== src/bte_pkg.sv =====
package bte_pkg;

  localparam int unsigned NUM_SLOTS = 5;

  // configuration register indexes
  localparam logic [1:0] CFG_DATA_START  = 2'd0;
  localparam logic [1:0] CFG_SECT_PER_CL = 2'd1;
  localparam logic [1:0] CFG_CLUST_COUNT = 2'd2;

  typedef struct packed {
    logic [31:0] lba;
    logic [31:0] cnt;
    logic        last;
  } ext_t;

  typedef struct packed {
    logic [16:0] cluster_index;
    logic        run_open;
    logic [31:0] run_start;
    logic [31:0] run_length;
    logic        pend_valid;
    logic [31:0] pend_start;
    logic [31:0] pend_length;
    logic        sys_closed;
    logic        map_done;
  } scan_state_t;

  typedef struct packed {
    logic [2:0]                 n;
    ext_t [NUM_SLOTS-1:0]       slot;
  } scan_res_t;

endpackage

// ===== src/bitmap_to_extent_list_top.sv =====
// Used-cluster bitmap to sector extent list.
// Input channel: one bitmap byte per transfer (in_valid / in_stall), bit 0
// is the lowest cluster. Output channel: one extent per transfer
// (out_valid / out_stall) with start sector, sector count and a last flag.
// Configuration: cfg_index / cfg_data written on cfg_valid (cfg_ready is
// always high); write only while no byte is in flight.
// The first extent caused by a byte is presented once the byte has passed
// the input register and been loaded into the extent buffer. Throughput:
// one byte per cycle while each byte yields at most one extent and
// out_stall is low; a byte that yields more holds the input until the
// single output port of the extent buffer (up to five deep) drains it.
// A byte can wait in the input register while results wait downstream, so
// in_stall rises only when the extent buffer cannot take the next byte's
// results. Once the map ends, further bytes are taken and dropped.
// Reset (rst_n low, synchronous) restores data_start 0, one sector per
// cluster, a one-cluster map, opens the system-area run and empties all
// buffers.
module bitmap_to_extent_list_top #(
  parameter int MAX_CLUSTERS = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_map_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_extent_lba,
  output logic [31:0] out_extent_count,
  output logic        out_last_extent,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import bte_pkg::*;

  // system-area run open, everything else clear
  localparam scan_state_t ST_RESET = '{
    cluster_index: 17'd0,
    run_open:      1'b1,
    run_start:     32'd0,
    run_length:    32'd0,
    pend_valid:    1'b0,
    pend_start:    32'd0,
    pend_length:   32'd0,
    sys_closed:    1'b0,
    map_done:      1'b0
  };

  logic [23:0] data_start_r;
  logic [7:0]  sect_per_cl_r;
  logic [16:0] clust_count_r;
  logic        in_valid_r;
  logic [7:0]  map_byte_r;
  scan_state_t st_r;
  scan_state_t st_nxt;
  scan_res_t   res;
  logic        q_free;
  logic        go;
  ext_t        out_ext;

  assign cfg_ready = 1'b1;
  assign go        = in_valid_r && q_free;
  assign in_stall  = in_valid_r && !go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r  <= 24'd0;
      sect_per_cl_r <= 8'd1;
      clust_count_r <= 17'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DATA_START:  data_start_r  <= cfg_data;
        CFG_SECT_PER_CL: sect_per_cl_r <= cfg_data[7:0];
        CFG_CLUST_COUNT: clust_count_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      map_byte_r <= in_map_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (go) begin
      st_r <= st_nxt;
    end
  end

  bte_scan #(
    .MAX_CLUSTERS(MAX_CLUSTERS)
  ) u_scan (
    .st          (st_r),
    .map_byte    (map_byte_r),
    .data_start  (data_start_r),
    .sect_per_cl (sect_per_cl_r),
    .clust_count (clust_count_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  bte_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go),
    .res       (res),
    .free      (q_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ext   (out_ext)
  );

  assign out_extent_lba   = out_ext.lba;
  assign out_extent_count = out_ext.cnt;
  assign out_last_extent  = out_ext.last;

endmodule

// ===== src/bte_scan.sv =====
module bte_scan #(
  parameter int MAX_CLUSTERS = 65536
) (
  input  bte_pkg::scan_state_t st,
  input  logic [7:0]           map_byte,
  input  logic [23:0]          data_start,
  input  logic [7:0]           sect_per_cl,
  input  logic [16:0]          clust_count,
  output bte_pkg::scan_state_t st_nxt,
  output bte_pkg::scan_res_t   res
);
  import bte_pkg::*;

  localparam logic [20:0] MAX_W = 21'(MAX_CLUSTERS);

  logic [16:0] lim;
  logic [24:0] prod;
  logic [31:0] base;
  logic [31:0] ds_term;
  logic [10:0] off [9];
  logic [31:0] start_lba [8];
  logic [31:0] rl_plus [9];
  logic [31:0] carr_len [9];
  logic [7:0]  lane_ok;
  logic        fin;

  assign lim     = ({4'b0, clust_count} > MAX_W) ? MAX_W[16:0] : clust_count;
  assign prod    = 25'(st.cluster_index) * 25'(sect_per_cl);
  assign base    = 32'(prod) + 32'(data_start);
  assign ds_term = st.sys_closed ? 32'd0 : 32'(data_start);
  assign fin     = ({1'b0, st.cluster_index} + 18'd8) >= {1'b0, lim};

  // per-lane offsets, starts and carried-run lengths, all in parallel
  always_comb begin
    for (int b = 0; b < 9; b++) begin
      off[b]      = 11'(sect_per_cl) * 11'(b);
      rl_plus[b]  = st.run_length + 32'(off[b]);
      carr_len[b] = rl_plus[b] + ds_term;
    end
    for (int b = 0; b < 8; b++) begin
      start_lba[b] = base + 32'(off[b]);
      lane_ok[b]   = ({1'b0, st.cluster_index} + 18'(b)) < {1'b0, lim};
    end
  end

  always_comb begin
    logic                 open_v;
    logic                 carried_v;
    logic                 pv_v;
    logic                 sysc_v;
    logic [2:0]           rs_v;
    logic [2:0]           n_v;
    logic [3:0]           nv_v;
    logic [31:0]          ps_v;
    logic [31:0]          pl_v;
    ext_t [NUM_SLOTS-1:0] slot_v;

    open_v    = st.run_open;
    carried_v = st.run_open;
    pv_v      = st.pend_valid;
    sysc_v    = st.sys_closed;
    rs_v      = 3'd0;
    n_v       = 3'd0;
    nv_v      = 4'd0;
    ps_v      = st.pend_start;
    pl_v      = st.pend_length;
    slot_v    = '0;

    for (int b = 0; b < 8; b++) begin
      if (lane_ok[b]) begin
        nv_v = nv_v + 4'd1;
        if (map_byte[b]) begin
          if (!open_v) begin
            // a new run releases the held extent
            if (pv_v) begin
              slot_v[n_v] = '{lba: ps_v, cnt: pl_v, last: 1'b0};
              n_v = n_v + 3'd1;
              pv_v = 1'b0;
            end
            open_v    = 1'b1;
            carried_v = 1'b0;
            rs_v      = 3'(b);
          end
        end else if (open_v) begin
          ps_v   = carried_v ? st.run_start : start_lba[rs_v];
          pl_v   = carried_v ? carr_len[b] : 32'(off[b] - off[{1'b0, rs_v}]);
          pv_v   = 1'b1;
          open_v = 1'b0;
          sysc_v = 1'b1;
        end
      end
    end

    st_nxt               = st;
    st_nxt.cluster_index = st.cluster_index + 17'(nv_v);
    st_nxt.sys_closed    = sysc_v;

    if (fin) begin
      // end of map: close an open run and flag the held extent as last
      if (open_v) begin
        ps_v   = carried_v ? st.run_start : start_lba[rs_v];
        pl_v   = carried_v ? carr_len[nv_v] : 32'(off[nv_v] - off[{1'b0, rs_v}]);
        pv_v   = 1'b1;
        open_v = 1'b0;
        st_nxt.sys_closed = 1'b1;
      end
      if (pv_v) begin
        slot_v[n_v] = '{lba: ps_v, cnt: pl_v, last: 1'b1};
        n_v = n_v + 3'd1;
        pv_v = 1'b0;
      end
      st_nxt.map_done = 1'b1;
    end else if (open_v) begin
      st_nxt.run_start  = carried_v ? st.run_start : start_lba[rs_v];
      st_nxt.run_length = carried_v ? rl_plus[8] : 32'(off[8] - off[{1'b0, rs_v}]);
    end

    st_nxt.run_open    = open_v;
    st_nxt.pend_valid  = pv_v;
    st_nxt.pend_start  = ps_v;
    st_nxt.pend_length = pl_v;

    res.n    = n_v;
    res.slot = slot_v;

    if (st.map_done) begin
      st_nxt = st;
      res.n  = 3'd0;
    end
  end

endmodule

// ===== src/bte_outq.sv =====
module bte_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  bte_pkg::scan_res_t res,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output bte_pkg::ext_t      out_ext
);
  import bte_pkg::*;

  ext_t [NUM_SLOTS-1:0] slot_r;
  logic [2:0]           cnt_r;
  logic [2:0]           rd_r;
  logic                 xfer;

  assign out_valid = cnt_r != rd_r;
  assign xfer      = out_valid && !out_stall;
  // room when empty, or once the last held extent leaves this cycle
  assign free      = !out_valid || ((cnt_r == rd_r + 3'd1) && !out_stall);

  always_comb begin
    out_ext = slot_r[0];
    for (int i = 1; i < NUM_SLOTS; i++) begin
      if (rd_r == 3'(i)) begin
        out_ext = slot_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      rd_r  <= 3'd0;
    end else if (load) begin
      cnt_r <= res.n;
      rd_r  <= 3'd0;
    end else if (xfer) begin
      rd_r <= rd_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= res.slot;
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import bte_pkg::*;

  localparam int MAX_CL = 65536;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_map_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_extent_lba;
  logic [31:0] out_extent_count;
  logic        out_last_extent;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_DATA_START;
  logic [23:0] cfg_data = 24'h0;

  bitmap_to_extent_list_top #(.MAX_CLUSTERS(MAX_CL)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_map_byte(in_map_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_extent_lba(out_extent_lba),
    .out_extent_count(out_extent_count),
    .out_last_extent(out_last_extent),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the register file
  logic [23:0] data_start = 24'd0;
  logic [7:0]  sect_per_cl = 8'd1;
  logic [16:0] clus_cnt = 17'd1;

  // mirror of the scan state
  logic [16:0] clus_idx = 17'd0;
  logic        run_open = 1'b1;
  logic [31:0] run_start = 32'd0;
  logic [31:0] run_len = 32'd0;
  logic        pend_valid = 1'b0;
  logic [31:0] pend_start = 32'd0;
  logic [31:0] pend_len = 32'd0;
  logic        sys_closed = 1'b0;
  logic        map_done = 1'b0;

  logic [7:0] map_q[$];
  ext_t       extent_q[$];

  int errors = 0;
  int n_bytes = 0;
  int n_dropped = 0;
  int n_extents = 0;
  int n_writes = 0;
  logic in_took = 1'b0;

  function automatic void note_extent(input logic [31:0] lba, input logic [31:0] cnt,
                                      input logic last);
    ext_t e;
    e.lba = lba;
    e.cnt = cnt;
    e.last = last;
    extent_q.push_back(e);
  endfunction

  function automatic void close_run();
    logic [31:0] len;
    len = run_len;
    if (!sys_closed) begin
      len = len + 32'(data_start);
      sys_closed = 1'b1;
    end
    pend_start = run_start;
    pend_len = len;
    pend_valid = 1'b1;
    run_open = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [7:0] bits);
    logic [16:0] lim;
    lim = (clus_cnt > 17'(MAX_CL)) ? 17'(MAX_CL) : clus_cnt;
    if (map_done) return;
    for (int b = 0; b < 8 && clus_idx < lim; b++) begin
      if (bits[b]) begin
        if (run_open) begin
          run_len = run_len + 32'(sect_per_cl);
        end else begin
          if (pend_valid) begin
            note_extent(pend_start, pend_len, 1'b0);
            pend_valid = 1'b0;
          end
          run_open = 1'b1;
          run_start = 32'(data_start) + 32'(clus_idx) * 32'(sect_per_cl);
          run_len = 32'(sect_per_cl);
        end
      end else if (run_open) begin
        close_run();
      end
      clus_idx = clus_idx + 17'd1;
    end
    if (clus_idx >= lim) begin
      if (run_open) close_run();
      if (pend_valid) begin
        note_extent(pend_start, pend_len, 1'b1);
        pend_valid = 1'b0;
      end
      map_done = 1'b1;
    end
  endfunction

  // sender: bursts of bytes separated by random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (map_q.size() != 0) begin
        in_map_byte <= map_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(0, 3);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: free flow, random, alternating, long holds
  int stall_mode = 0;
  int mode_left = 50;
  int hold_left = 0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(40, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ~out_stall;
      default: begin
        if (hold_left != 0) begin
          out_stall <= 1'b1;
          hold_left <= hold_left - 1;
        end else begin
          out_stall <= 1'b0;
          hold_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : 0;
        end
      end
    endcase
  end

  always @(posedge clk) begin : watch
    ext_t want;
    in_took <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      n_bytes++;
      if (map_done) n_dropped++;
      scan_byte(in_map_byte);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (extent_q.size() == 0) begin
        $error("extent (%0h, %0h) with nothing expected", out_extent_lba, out_extent_count);
        errors++;
      end else begin
        want = extent_q.pop_front();
        n_extents++;
        if (out_extent_lba !== want.lba) begin
          $error("extent_lba expected %0h got %0h", want.lba, out_extent_lba);
          errors++;
        end
        if (out_extent_count !== want.cnt) begin
          $error("extent_count expected %0h got %0h", want.cnt, out_extent_count);
          errors++;
        end
        if (out_last_extent !== want.last) begin
          $error("last_extent expected %0b got %0b", want.last, out_last_extent);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DATA_START:  data_start = val;
      CFG_SECT_PER_CL: sect_per_cl = val[7:0];
      CFG_CLUST_COUNT: clus_cnt = val[16:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender drained, every extent arrived, then room for a byte with no extent
  task automatic wait_quiet();
    @(negedge clk);
    while (map_q.size() != 0 || in_valid || extent_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte(input int style);
    case (style)
      0: return 8'($urandom);
      1: return ($urandom_range(0, 3) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
      2: return ($urandom_range(0, 3) == 0) ? ~8'(1 << $urandom_range(0, 7)) : 8'hFF;
      default: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  initial begin
    int style;
    int k;
    logic [7:0] last_byte;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // cluster 0 free with no system area gives an empty first extent
    write_reg(CFG_DATA_START, 24'd0);
    write_reg(CFG_SECT_PER_CL, 24'd1);
    write_reg(CFG_CLUST_COUNT, 24'h01FFFF);
    foreach (map_q[i]) ;
    map_q = '{8'h00, 8'hFF, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h00, 8'h81,
              8'h7E, 8'h10, 8'hF0, 8'h0F};
    wait_quiet();

    write_reg(CFG_DATA_START, 24'hFFFFFF);
    write_reg(CFG_SECT_PER_CL, 24'd128);
    map_q = '{8'hAA, 8'h55, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h33, 8'hCC, 8'hFE, 8'h7F};
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(CFG_DATA_START, 24'hFFFFFF);
          write_reg(CFG_SECT_PER_CL, 24'd0);
        end
        1: begin
          write_reg(CFG_DATA_START, 24'd0);
          write_reg(CFG_SECT_PER_CL, 24'd255);
          write_reg(CFG_CLUST_COUNT, 24'd65536);
        end
        default: begin
          write_reg(CFG_DATA_START, 24'($urandom_range(0, 24'hFFFFFF)));
          write_reg(CFG_SECT_PER_CL, 24'($urandom_range(1, 128)));
          if ($urandom_range(0, 1) == 1)
            write_reg(CFG_CLUST_COUNT, 24'($urandom_range(20000, 131071)));
        end
      endcase
      style = $urandom_range(0, 3);
      for (int i = 0; i < 58; i++) begin
        if ($urandom_range(0, 9) == 0) style = $urandom_range(0, 3);
        map_q.push_back(pick_byte(style));
      end
      wait_quiet();
    end

    // end the map: usually inside a byte, sometimes by shrinking to the index or below
    k = $urandom_range(1, 7);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_CLUST_COUNT, 24'($urandom_range(0, clus_idx)));
    end else begin
      write_reg(CFG_CLUST_COUNT, 24'(clus_idx + 17'(k)));
    end
    last_byte = 8'($urandom) | 8'(1 << (k - 1)) | 8'h80;
    map_q.push_back(last_byte);
    for (int i = 0; i < 6; i++) map_q.push_back(8'($urandom));
    wait_quiet();

    // registers still take writes after the end, with no effect on the scan
    write_reg(CFG_CLUST_COUNT, 24'd0);
    write_reg(CFG_DATA_START, 24'd0);
    map_q = '{8'hFF, 8'h00, 8'hA5};
    wait_quiet();
    repeat (20) @(posedge clk);

    $display("scanned %0d bitmap bytes (%0d after the map ended), checked %0d extents",
             n_bytes, n_dropped, n_extents);
    $display("%0d register writes across system-area, cluster-size and map-length settings",
             n_writes);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== bitmap_to_extent_list_top.f =====
src/bte_pkg.sv
src/bte_scan.sv
src/bte_outq.sv
src/bitmap_to_extent_list_top.sv
sim/testbench.sv
